// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TMQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define TMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TMQ_ASSERT(lbl, prop, msg)
`define TMQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/tmq_pkg.sv =====
// ----------------------------------------------------------------------------
// Typed message queue package
// Sizes, status codes and the control bundle shared by the queue cells.
// ----------------------------------------------------------------------------
package tmq_pkg;

    localparam int DEPTH         = 16;
    localparam int PAYLOAD_BYTES = 8;
    localparam int TYPE_W        = 32;
    localparam int PORT_PAY_W    = 64;
    localparam int PAY_W         = PAYLOAD_BYTES * 8;
    localparam int CNT_W         = $clog2(DEPTH + 1);

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOMATCH = 2'd2;

    localparam logic ACT_SEND    = 1'b0;
    localparam logic ACT_RECEIVE = 1'b1;

    // Broadcast to every cell in the cycle a request is taken.
    typedef struct packed {
        logic              append;
        logic              receive;
        logic [TYPE_W-1:0] key;
        logic [PAY_W-1:0]  data;
    } t_cell_ctrl;

endpackage

// ===== rtl/tmq_cell.sv =====
// ----------------------------------------------------------------------------
// Typed message queue cell
// One slot: holds a type and payload, matches against the search key, and
// takes its right neighbor's contents when a message at or before it leaves.
// ----------------------------------------------------------------------------
module tmq_cell (
    input  logic                            i_clk,
    input  tmq_pkg::t_cell_ctrl             i_ctrl,
    input  logic                            i_occupied,
    input  logic                            i_tail,
    input  logic                            i_hit,
    input  logic [tmq_pkg::PAY_W-1:0]       i_pay_acc,
    input  logic [tmq_pkg::TYPE_W-1:0]      i_next_type,
    input  logic [tmq_pkg::PAY_W-1:0]       i_next_pay,
    output logic                            o_hit,
    output logic [tmq_pkg::PAY_W-1:0]       o_pay_acc,
    output logic [tmq_pkg::TYPE_W-1:0]      o_type,
    output logic [tmq_pkg::PAY_W-1:0]       o_pay
);

    logic [tmq_pkg::TYPE_W-1:0] r_type;
    logic [tmq_pkg::PAY_W-1:0]  r_pay;
    logic [tmq_pkg::TYPE_W-1:0] n_type;
    logic [tmq_pkg::PAY_W-1:0]  n_pay;
    logic                       w_match;
    logic                       w_first;

    assign w_match   = i_occupied && (r_type == i_ctrl.key);
    assign w_first   = w_match && !i_hit;
    assign o_hit     = i_hit || w_match;
    assign o_pay_acc = i_pay_acc | (w_first ? r_pay : '0);
    assign o_type    = r_type;
    assign o_pay     = r_pay;

    always_comb begin
        n_type = r_type;
        n_pay  = r_pay;
        if (i_ctrl.append && i_tail) begin
            n_type = i_ctrl.key;
            n_pay  = i_ctrl.data;
        end else if (i_ctrl.receive && o_hit) begin
            // The removed slot and every later one move down by one.
            n_type = i_next_type;
            n_pay  = i_next_pay;
        end
    end

    always_ff @(posedge i_clk) begin
        r_type <= n_type;
        r_pay  <= n_pay;
    end

endmodule

// ===== rtl/typed_message_queue.sv =====
// ----------------------------------------------------------------------------
// Typed message queue
// Ordered store of typed messages with receive-by-type and gap closing.
// ----------------------------------------------------------------------------
// Usage: a request on i_valid/o_stall carries i_action, i_msg_type and
// i_payload. A send appends the message at the tail, or reports full. A
// receive returns the oldest message of the requested type, removes it and
// shifts later messages down, or reports no match. Every request yields one
// result on o_valid/i_stall with o_status, o_payload_out and o_entries_held.
// The result appears in the cycle after its request is taken. One request per
// cycle is taken while o_stall is low; the single pass through the row of slot
// cells, whose match chain and shift settle in the cycle the request is taken,
// allows this. The result sits in an output register; while the receiver stalls
// a held result, o_stall is raised and no new request is taken. Reset empties
// the store and drops any pending result; slot contents are not cleared.
// ----------------------------------------------------------------------------
module typed_message_queue (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_action,
    input  logic signed [tmq_pkg::TYPE_W-1:0] i_msg_type,
    input  logic [tmq_pkg::PORT_PAY_W-1:0]    i_payload,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [1:0]                        o_status,
    output logic [tmq_pkg::PORT_PAY_W-1:0]    o_payload_out,
    output logic [tmq_pkg::CNT_W-1:0]         o_entries_held
);

    localparam int D = tmq_pkg::DEPTH;

    tmq_pkg::t_cell_ctrl w_ctrl;
    logic                w_accept;
    logic                w_full;
    logic                w_found;
    logic                w_full_send;
    logic                w_out_fail;
    logic [D-1:0]        w_occ;
    logic [D-1:0]        w_tail;
    logic [D:0]          w_hit;
    logic [tmq_pkg::PAY_W-1:0]  w_acc  [D+1];
    logic [tmq_pkg::TYPE_W-1:0] w_type [D];
    logic [tmq_pkg::PAY_W-1:0]  w_pay  [D];

    logic [tmq_pkg::CNT_W-1:0]       r_count, n_count;
    logic                            r_out_valid, n_out_valid;
    logic [1:0]                      r_status, n_status;
    logic [tmq_pkg::PORT_PAY_W-1:0]  r_result, n_result;

    assign o_stall  = r_out_valid && i_stall;
    assign w_accept = i_valid && !o_stall;
    assign w_full   = (r_count == tmq_pkg::CNT_W'(D));

    assign w_ctrl.append  = w_accept && (i_action == tmq_pkg::ACT_SEND) && !w_full;
    assign w_ctrl.receive = w_accept && (i_action == tmq_pkg::ACT_RECEIVE);
    assign w_ctrl.key     = i_msg_type;
    assign w_ctrl.data    = i_payload[tmq_pkg::PAY_W-1:0];

    assign w_hit[0] = 1'b0;
    assign w_acc[0] = '0;

    for (genvar g = 0; g < D; g++) begin : g_cell
        assign w_occ[g]  = (tmq_pkg::CNT_W'(g) < r_count);
        assign w_tail[g] = (tmq_pkg::CNT_W'(g) == r_count);

        tmq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_occupied  (w_occ[g]),
            .i_tail      (w_tail[g]),
            .i_hit       (w_hit[g]),
            .i_pay_acc   (w_acc[g]),
            .i_next_type (w_type[(g < D - 1) ? g + 1 : g]),
            .i_next_pay  (w_pay[(g < D - 1) ? g + 1 : g]),
            .o_hit       (w_hit[g+1]),
            .o_pay_acc   (w_acc[g+1]),
            .o_type      (w_type[g]),
            .o_pay       (w_pay[g])
        );
    end

    assign w_found = w_hit[D];

    always_comb begin
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_result    = r_result;
        if (w_accept) begin
            n_out_valid = 1'b1;
            n_result    = '0;
            n_status    = tmq_pkg::ST_OK;
            case (i_action)
                tmq_pkg::ACT_SEND: begin
                    if (w_full) begin
                        n_status = tmq_pkg::ST_FULL;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
                tmq_pkg::ACT_RECEIVE: begin
                    if (w_found) begin
                        n_result = tmq_pkg::PORT_PAY_W'(w_acc[D]);
                        n_count  = r_count - 1'b1;
                    end else begin
                        n_status = tmq_pkg::ST_NOMATCH;
                    end
                end
                default: begin
                    n_status = tmq_pkg::ST_OK;
                end
            endcase
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_status <= n_status;
        r_result <= n_result;
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_payload_out  = r_result;
    assign o_entries_held = r_count;

    assign w_full_send = w_accept && (i_action == tmq_pkg::ACT_SEND) && w_full;
    assign w_out_fail  = o_valid && (o_status != tmq_pkg::ST_OK);

`include "assert_macros.svh"

    `TMQ_ASSERT(a_count_bound, r_count <= tmq_pkg::CNT_W'(D), "fill count above depth")
    `TMQ_ASSERT_NEXT(a_idle_count, !w_accept, $stable(r_count), "count moved without a request")
    `TMQ_ASSERT_NEXT(a_full_send, w_full_send, o_status == tmq_pkg::ST_FULL, "full not flagged")
    `TMQ_ASSERT_NEXT(a_full_hold, w_full_send, $stable(r_count), "send on full store moved count")
    `TMQ_ASSERT(a_fail_zero, !w_out_fail || (o_payload_out == '0), "failed request gave payload")

endmodule

// ===== test/typed_message_queue_test.sv =====
// ----------------------------------------------------------------------------
// Typed message queue testbench
// Drives send and receive requests into the queue and keeps its own copy of
// the stored messages. Each result is checked against the predicted status,
// payload and fill level, under random idling on both sides and back-pressure.
// ----------------------------------------------------------------------------
module typed_message_queue_test;

    localparam int QUIET_LIMIT = 2000;
    localparam int REPORT_MAX  = 10;
    localparam logic [tmq_pkg::PORT_PAY_W-1:0] KEEP_MASK =
        {tmq_pkg::PORT_PAY_W{1'b1}} >> (tmq_pkg::PORT_PAY_W - tmq_pkg::PAY_W);

    typedef struct packed {
        logic [1:0]                     status;
        logic [tmq_pkg::PORT_PAY_W-1:0] payload;
        logic [tmq_pkg::CNT_W-1:0]      entries;
    } t_queue_result;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_valid;
    logic                                o_stall;
    logic                                i_action;
    logic signed [tmq_pkg::TYPE_W-1:0]   i_msg_type;
    logic [tmq_pkg::PORT_PAY_W-1:0]      i_payload;
    logic                                o_valid;
    logic                                i_stall;
    logic [1:0]                          o_status;
    logic [tmq_pkg::PORT_PAY_W-1:0]      o_payload_out;
    logic [tmq_pkg::CNT_W-1:0]           o_entries_held;

    // Mirror of the queue contents, oldest message first.
    logic [tmq_pkg::TYPE_W-1:0]     held_types[$];
    logic [tmq_pkg::PORT_PAY_W-1:0] held_payloads[$];
    t_queue_result                  expected_results[$];

    int failure_count   = 0;
    int quiet_cycles    = 0;
    int sender_idle_pct = 0;
    int recv_idle_pct   = 0;
    int hold_off_len    = 0;

    typed_message_queue uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_msg_type     (i_msg_type),
        .i_payload      (i_payload),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_payload_out  (o_payload_out),
        .o_entries_held (o_entries_held)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Applies one request to the mirror and returns the result it must give.
    function automatic t_queue_result apply_request(logic act,
                                                    logic [tmq_pkg::TYPE_W-1:0] key,
                                                    logic [tmq_pkg::PORT_PAY_W-1:0] word);
        t_queue_result res;
        int hit;
        res = '{status: tmq_pkg::ST_OK, payload: '0, entries: '0};
        hit = -1;
        if (act == tmq_pkg::ACT_SEND) begin
            if (held_types.size() >= tmq_pkg::DEPTH) begin
                res.status = tmq_pkg::ST_FULL;
            end else begin
                held_types.push_back(key);
                held_payloads.push_back(word & KEEP_MASK);
            end
        end else begin
            foreach (held_types[i]) begin
                if (hit < 0 && held_types[i] == key) hit = i;
            end
            if (hit < 0) begin
                res.status = tmq_pkg::ST_NOMATCH;
            end else begin
                // Removing from the middle closes the gap, as the cells shift down.
                res.payload = held_payloads[hit];
                held_types.delete(hit);
                held_payloads.delete(hit);
            end
        end
        res.entries = tmq_pkg::CNT_W'(held_types.size());
        return res;
    endfunction

    function automatic void log_failure(string what, t_queue_result want,
                                        t_queue_result seen);
        failure_count++;
        if (failure_count <= REPORT_MAX)
            $display("%s: status exp %0d got %0d, payload exp %h got %h, %s %0d got %0d",
                     what, want.status, seen.status, want.payload, seen.payload,
                     "entries exp", want.entries, seen.entries);
    endfunction

    // Requests are predicted before results are checked, so the order holds
    // even if a result came in the same cycle as its request.
    always @(posedge i_clk) begin
        t_queue_result seen;
        t_queue_result want;
        if (i_rst_n) begin
            quiet_cycles++;
            if (i_valid && !o_stall) begin
                expected_results.push_back(apply_request(i_action, i_msg_type, i_payload));
                quiet_cycles = 0;
            end
            if (o_valid && !i_stall) begin
                seen = '{o_status, o_payload_out, o_entries_held};
                quiet_cycles = 0;
                if (expected_results.size() == 0) begin
                    log_failure("result with no request pending", '0, seen);
                end else begin
                    want = expected_results.pop_front();
                    if (seen.status !== want.status || seen.payload !== want.payload ||
                        seen.entries !== want.entries)
                        log_failure("result mismatch", want, seen);
                end
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when a test asks for one.
    initial begin
        int hold_count;
        hold_count = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_len > 0) begin
                hold_count = hold_off_len;
                hold_off_len = 0;
            end
            if (hold_count > 0) begin
                i_stall <= 1'b1;
                hold_count--;
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    task automatic send_request(logic act, logic [tmq_pkg::TYPE_W-1:0] key,
                                logic [tmq_pkg::PORT_PAY_W-1:0] word);
        if ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_action   <= act;
        i_msg_type <= key;
        i_payload  <= word;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // The extra edge lets the last accepted request reach the prediction.
    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        sender_idle_pct = 0;
        recv_idle_pct   = 0;
        send_request(tmq_pkg::ACT_RECEIVE, 32'h0000_0000, '1);   // empty store, no match
        send_request(tmq_pkg::ACT_SEND, 32'h8000_0000, '1);
        send_request(tmq_pkg::ACT_SEND, 32'h7FFF_FFFF, '0);
        send_request(tmq_pkg::ACT_SEND, 32'hFFFF_FFFF, 64'h8000_0000_0000_0001);
        send_request(tmq_pkg::ACT_SEND, 32'h7FFF_FFFF, 64'h0123_4567_89AB_CDEF);
        // Two messages share this type; the older one in the middle must go.
        send_request(tmq_pkg::ACT_RECEIVE, 32'h7FFF_FFFF, '1);
        send_request(tmq_pkg::ACT_RECEIVE, 32'h0000_0001, '0);
        for (int n = 0; n < 13; n++)
            send_request(tmq_pkg::ACT_SEND, tmq_pkg::TYPE_W'(n), {2{32'(n)}});
        // Store full.
        send_request(tmq_pkg::ACT_SEND, 32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        send_request(tmq_pkg::ACT_RECEIVE, 32'hFFFF_FFFF, '0);
        send_request(tmq_pkg::ACT_RECEIVE, 32'h0000_000C, '0);   // newest message
        send_request(tmq_pkg::ACT_RECEIVE, 32'h8000_0000, '0);   // oldest message
    endtask

    task automatic test_receiver_hold();
        sender_idle_pct = 0;
        recv_idle_pct   = 0;
        hold_off_len    = 80;
        for (int n = 0; n < 40; n++)
            send_request($urandom_range(3) == 0 ? tmq_pkg::ACT_RECEIVE : tmq_pkg::ACT_SEND,
                         $urandom_range(3), {$urandom, $urandom});
    endtask

    task automatic test_random(int count, int send_idle, int recv_idle);
        logic [tmq_pkg::TYPE_W-1:0] type_pool[4];
        logic [tmq_pkg::TYPE_W-1:0] key;
        logic                       act;
        int                         send_pct;
        sender_idle_pct = send_idle;
        recv_idle_pct   = recv_idle;
        type_pool = '{32'h8000_0000, 32'h7FFF_FFFF, $urandom_range(7), $urandom};
        send_pct = 50;
        for (int n = 0; n < count; n++) begin
            // Shifting the mix keeps the store wandering between empty and full.
            if (n % 50 == 0) send_pct = $urandom_range(15, 85);
            act = ($urandom_range(99) < send_pct) ? tmq_pkg::ACT_SEND : tmq_pkg::ACT_RECEIVE;
            key = ($urandom_range(9) < 8) ? type_pool[$urandom_range(3)] : $urandom;
            send_request(act, key, {$urandom, $urandom});
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_action   <= tmq_pkg::ACT_SEND;
        i_msg_type <= '0;
        i_payload  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        wait_for_results();
        test_receiver_hold();
        wait_for_results();
        test_random(500, 7, 61);
        test_random(500, 61, 7);
        test_random(550, 0, 0);
        wait_for_results();
        repeat (4) @(posedge i_clk);

        if (failure_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== typed_message_queue.f =====
+incdir+rtl
rtl/tmq_pkg.sv
rtl/tmq_cell.sv
rtl/typed_message_queue.sv
test/typed_message_queue_test.sv
